>>> rtl/assert_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

`else

`define ASSERT_ALWAYS(name, clk, rst_n, prop)
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/cffba_pkg.sv
// Package with constants, codes and interface types of the block allocator.
`default_nettype none

package cffba_pkg;

    localparam int POOL_BLOCKS = 64;
    localparam int BLOCK_W     = $clog2(POOL_BLOCKS);
    localparam int COUNT_W     = BLOCK_W + 1;
    localparam int SUM_W       = COUNT_W + 1;
    localparam int LANES       = 8;
    localparam int LANE_W      = $clog2(LANES);
    localparam int CHUNK_W     = BLOCK_W - LANE_W;
    localparam int STATUS_W    = 2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FAIL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NULL = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_APPLY
    } ctrl_state_t;

    typedef struct packed {
        logic load_req;
        logic scan_step;
        logic apply;
    } dp_cmd_t;

    typedef struct packed {
        logic eligible;
        logic scan_done;
    } dp_sts_t;

endpackage

`default_nettype wire

>>> rtl/cffba_ctrl.sv
// Controller state machine that sequences check, scan and update of one item.
`default_nettype none
`include "assert_macros.svh"

module cffba_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    input  wire cffba_pkg::dp_sts_t sts,
    output cffba_pkg::dp_cmd_t     cmd
);
    import cffba_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.eligible) begin
                    state_next = ST_SCAN;
                end else begin
                    state_next = ST_APPLY;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.apply    = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

    `ASSERT_IMPLIES(a_out_from_apply, aclk, aresetn, $rose(m_valid_reg), $past(state_reg == ST_APPLY))
    `ASSERT_IMPLIES(a_accept_to_check, aclk, aresetn, $past(s_valid && s_ready), state_reg == ST_CHECK)

endmodule

`default_nettype wire

>>> rtl/cffba_dp.sv
// Datapath holding the block map, the allocated count, the run scanner and result registers.
`default_nettype none
`include "assert_macros.svh"

module cffba_dp (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire cffba_pkg::dp_cmd_t                cmd,
    output cffba_pkg::dp_sts_t                     sts,
    input  wire logic                              s_op,
    input  wire logic [cffba_pkg::COUNT_W-1:0]     s_block_count,
    input  wire logic [cffba_pkg::BLOCK_W-1:0]     s_start_block,
    input  wire logic                              s_null_handle,
    output logic [cffba_pkg::STATUS_W-1:0]         m_status,
    output logic [cffba_pkg::BLOCK_W-1:0]          m_granted_block,
    output logic [cffba_pkg::COUNT_W-1:0]          m_free_blocks
);
    import cffba_pkg::*;

    logic [POOL_BLOCKS-1:0] used_reg, used_next;
    logic [COUNT_W-1:0]     alloc_reg, alloc_next;

    logic                   op_reg;
    logic [COUNT_W-1:0]     count_reg;
    logic [BLOCK_W-1:0]     start_reg;
    logic                   null_reg;

    logic [CHUNK_W-1:0]     chunk_reg;
    logic [COUNT_W-1:0]     run_reg, run_next;
    logic                   found_reg, found_next;
    logic [BLOCK_W-1:0]     grant_reg, grant_next;
    logic [COUNT_W-1:0]     grant_end;

    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [BLOCK_W-1:0]     granted_reg, granted_next;
    logic [COUNT_W-1:0]     free_reg;

    logic [COUNT_W-1:0]     free_now;

    assign free_now     = COUNT_W'(POOL_BLOCKS) - alloc_reg;
    assign grant_end    = {1'b0, grant_reg} + count_reg;
    assign sts.eligible = (op_reg == OP_ALLOC) && (count_reg != '0)
                          && (count_reg <= COUNT_W'(POOL_BLOCKS)) && (count_reg <= free_now);

    // Scan one chunk of the map, tracking the length of the current free run.
    always_comb begin
        logic [BLOCK_W-1:0] idx_v;
        logic [COUNT_W-1:0] pos_v;
        pos_v      = '0;
        run_next   = run_reg;
        found_next = found_reg;
        grant_next = grant_reg;
        for (int j = 0; j < LANES; j++) begin
            idx_v = {chunk_reg, LANE_W'(j)};
            if (used_reg[idx_v]) begin
                run_next = '0;
            end else begin
                run_next = run_next + 1'b1;
            end
            if (!found_next && (run_next == count_reg)) begin
                found_next = 1'b1;
                pos_v      = {1'b0, idx_v} + 1'b1 - count_reg;
                grant_next = pos_v[BLOCK_W-1:0];
            end
        end
    end

    assign sts.scan_done = found_next || (chunk_reg == '1);

    // Apply the allocation or the release to the map and the count.
    always_comb begin
        logic [SUM_W-1:0] base_v;
        logic [SUM_W-1:0] end_v;
        logic             hit_v;
        used_next    = used_reg;
        alloc_next   = alloc_reg;
        status_next  = STATUS_DONE;
        granted_next = '0;
        base_v       = (op_reg == OP_ALLOC) ? SUM_W'(grant_reg) : SUM_W'(start_reg);
        end_v        = (op_reg == OP_ALLOC) ? SUM_W'(grant_end) : base_v + SUM_W'(count_reg);
        for (int i = 0; i < POOL_BLOCKS; i++) begin
            hit_v = (SUM_W'(i) >= base_v) && (SUM_W'(i) < end_v);
            if (op_reg == OP_ALLOC) begin
                if (hit_v && found_reg) begin
                    used_next[i] = 1'b1;
                end
            end else if (!null_reg) begin
                if (hit_v) begin
                    used_next[i] = 1'b0;
                end
            end
        end
        if (op_reg == OP_ALLOC) begin
            if (found_reg) begin
                alloc_next   = alloc_reg + count_reg;
                granted_next = grant_reg;
            end else begin
                status_next = STATUS_FAIL;
            end
        end else if (null_reg) begin
            status_next = STATUS_NULL;
        end else if (alloc_reg > count_reg) begin
            alloc_next = alloc_reg - count_reg;
        end else begin
            alloc_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg  <= '0;
            alloc_reg <= '0;
        end else if (cmd.apply) begin
            used_reg  <= used_next;
            alloc_reg <= alloc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (cmd.load_req) begin
            op_reg    <= s_op;
            count_reg <= s_block_count;
            start_reg <= s_start_block;
            null_reg  <= s_null_handle;
            chunk_reg <= '0;
            run_reg   <= '0;
            found_reg <= 1'b0;
            grant_reg <= '0;
        end else if (cmd.scan_step) begin
            chunk_reg <= chunk_reg + 1'b1;
            run_reg   <= run_next;
            found_reg <= found_next;
            grant_reg <= grant_next;
        end
        if (cmd.apply) begin
            status_reg  <= status_next;
            granted_reg <= granted_next;
            free_reg    <= COUNT_W'(POOL_BLOCKS) - alloc_next;
        end
    end

    assign m_status        = status_reg;
    assign m_granted_block = granted_reg;
    assign m_free_blocks   = free_reg;

    `ASSERT_ALWAYS(a_alloc_bound, aclk, aresetn, alloc_reg <= COUNT_W'(POOL_BLOCKS))
    `ASSERT_IMPLIES(a_grant_fits, aclk, aresetn, found_reg, grant_end <= COUNT_W'(POOL_BLOCKS))

endmodule

`default_nettype wire

>>> rtl/contiguous_first_fit_block_allocator_top.sv
// Top level of the contiguous first-fit block allocator.
//
//  Channel  Direction  Handshake           Payload
//  s_       in         s_valid / s_ready   op, block_count, start_block, null_handle
//  m_       out        m_valid / m_ready   status, granted_block, free_blocks
//
// An allocation that needs a run search goes through the run scanner, which examines
// 8 blocks of the map per cycle; items that need no run search skip the scan.
// Reset is synchronous and active low; it frees every block and clears the count.
// One item is in work at a time; the next item is taken while a result waits.
// A stalled result register holds the block in its update step until it drains.
`default_nettype none

module contiguous_first_fit_block_allocator_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_op,
    input  wire logic [cffba_pkg::COUNT_W-1:0]     s_block_count,
    input  wire logic [cffba_pkg::BLOCK_W-1:0]     s_start_block,
    input  wire logic                              s_null_handle,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [cffba_pkg::STATUS_W-1:0]         m_status,
    output logic [cffba_pkg::BLOCK_W-1:0]          m_granted_block,
    output logic [cffba_pkg::COUNT_W-1:0]          m_free_blocks
);
    import cffba_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    cffba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    cffba_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_op            (s_op),
        .s_block_count   (s_block_count),
        .s_start_block   (s_start_block),
        .s_null_handle   (s_null_handle),
        .m_status        (m_status),
        .m_granted_block (m_granted_block),
        .m_free_blocks   (m_free_blocks)
    );

endmodule

`default_nettype wire
